// ----- rtl/smte_pkg.sv -----
// Shared types, codes and constants for the stage move time estimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package smte_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_MOVED     = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_NOT_CONN  = 3'd2,
		ST_NOT_EN    = 3'd3,
		ST_NOT_HOMED = 3'd4,
		ST_HOMED     = 3'd5
	} status_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_CONNECTED = 3'd0;
	localparam logic [2:0] CFG_ENABLED   = 3'd1;
	localparam logic [2:0] CFG_VELOCITY  = 3'd2;
	localparam logic [2:0] CFG_ACCEL     = 3'd3;
	localparam logic [2:0] CFG_MIN_POS   = 3'd4;
	localparam logic [2:0] CFG_MAX_POS   = 3'd5;

	// Input kind codes
	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_HOME = 1'b1;

	// Shared multiplier operand selection
	typedef enum logic [1:0] {
		MUL_DA = 2'd0,
		MUL_VV = 2'd1,
		MUL_VA = 2'd2,
		MUL_KD = 2'd3
	} mul_sel_t;

	// Divider and square root sizes
	localparam int DVD_W      = 77;
	localparam int DEN_W      = 65;
	localparam int SQ_W       = 56;
	localparam int DIV_STEPS  = DVD_W;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int CNT_W      = 7;

	// 16e6 scales d/a so that its root gives twice the time in ms
	localparam logic [31:0] SQ_SCALE = 32'd16000000;

	// Controller states
	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CHECK  = 11'b000_0000_0010,
		S_MDA    = 11'b000_0000_0100,
		S_MVV    = 11'b000_0000_1000,
		S_MVA    = 11'b000_0001_0000,
		S_MKD    = 11'b000_0010_0000,
		S_PREP   = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_SQINIT = 11'b001_0000_0000,
		S_SQRT   = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     latch_short;
		logic     div_init;
		logic     div_step;
		logic     sq_init;
		logic     sq_step;
		logic     fin;
		logic     out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_time;
		logic short_move;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/stage_move_time_estimator.sv -----
// Top level of the stage move time estimator: controller plus datapath.
// Depends on smte_pkg, smte_ctrl and smte_dp.
//
// Each command produces exactly one result. Home events, refused moves
// and moves to the current position go from the check state straight to
// the output register. A long move passes three times through the shared
// 32x32 multiplier and then the 77-step restoring divider (one quotient
// bit per cycle); a short move adds a fourth multiplier pass and the
// 28-step square root. The next command can be taken in the same cycle
// as the result appears. One command is worked at a time; a finished
// result waits in the output register while the receiver stalls it, and
// a later result that is ready meanwhile holds off the next command until
// the register is free.
// Configuration writes are always taken and must arrive while idle.
`timescale 1ns / 1ps
module stage_move_time_estimator import smte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] target_position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] position,
	output logic [31:0] move_time_ms
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequence the work
	smte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold state and compute
	smte_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.target_position (target_position),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.position        (position),
		.move_time_ms    (move_time_ms)
	);

endmodule

// ----- rtl/smte_ctrl.sv -----
// Controller state machine of the stage move time estimator.
// Depends on smte_pkg; sequences the datapath in smte_dp.
`timescale 1ns / 1ps
module smte_ctrl import smte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              done_q, done_d;

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	assign in_stall = (state_q != S_IDLE) || done_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = done_q;
		cmd     = '0;
		cmd.mul_sel = MUL_DA;
		if (done_q) begin
			// hold until the output register is free
			if (sts.out_free) begin
				cmd.out_load = 1'b1;
				done_d       = 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.need_time) begin
						state_d = S_MDA;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
				S_MDA: begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_DA;
					state_d     = S_MVV;
				end
				S_MVV: begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_VV;
					state_d     = S_MVA;
				end
				S_MVA: begin
					cmd.mul_en      = 1'b1;
					cmd.mul_sel     = MUL_VA;
					cmd.latch_short = 1'b1;
					state_d         = S_MKD;
				end
				S_MKD: begin
					// short move needs 16e6*d as dividend
					cmd.mul_en  = sts.short_move;
					cmd.mul_sel = MUL_KD;
					state_d     = S_PREP;
				end
				S_PREP: begin
					cmd.div_init = 1'b1;
					cnt_d        = CNT_W'(DIV_STEPS - 1);
					state_d      = S_DIV;
				end
				S_DIV: begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_d = sts.short_move ? S_SQINIT : S_FIN;
					end
				end
				S_SQINIT: begin
					cmd.sq_init = 1'b1;
					cnt_d       = CNT_W'(SQRT_STEPS - 1);
					state_d     = S_SQRT;
				end
				S_SQRT: begin
					cmd.sq_step = 1'b1;
					cnt_d       = cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_d = S_FIN;
					end
				end
				S_FIN: begin
					cmd.fin = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/smte_dp.sv -----
// Datapath of the stage move time estimator: configuration, position
// state, shared multiplier, divider, square root and output register.
// Depends on smte_pkg; driven by smte_ctrl.
`timescale 1ns / 1ps
module smte_dp import smte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        kind,
	input  logic [31:0] target_position,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] position,
	output logic [31:0] move_time_ms
);

	logic               connected_q, enabled_q;
	logic [31:0]        velocity_q, accel_q;
	logic signed [31:0] min_pos_q, max_pos_q;
	logic signed [31:0] cur_pos_q;
	logic               homed_q;

	status_t            st_q;
	logic               need_q;
	logic [31:0]        dist_q;
	logic [63:0]        da_q, vv_q, va_q;
	logic               short_q;
	logic [DVD_W-1:0]   dvd_q, quo_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W:0]     rem_q;
	logic [SQ_W-1:0]    sqn_q, sqr_q, sqb_q;
	logic [31:0]        ms_q;
	logic               out_valid_q;
	status_t            out_st_q;
	logic [31:0]        out_pos_q, out_ms_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			enabled_q   <= 1'b0;
			velocity_q  <= 32'd65536;
			accel_q     <= 32'd65536;
			min_pos_q   <= 32'sh8000_0000;
			max_pos_q   <= 32'sh7FFF_FFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONNECTED: connected_q <= cfg_data[0];
				CFG_ENABLED:   enabled_q   <= cfg_data[0];
				CFG_VELOCITY:  velocity_q  <= cfg_data;
				CFG_ACCEL:     accel_q     <= cfg_data;
				CFG_MIN_POS:   min_pos_q   <= cfg_data;
				CFG_MAX_POS:   max_pos_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero velocity or acceleration counts as one
	logic [31:0] v_eff, a_eff;
	assign v_eff = (velocity_q == '0) ? 32'd1 : velocity_q;
	assign a_eff = (accel_q == '0) ? 32'd1 : accel_q;

	// Clamp target: lower to max first, then raise to min
	logic signed [31:0] tgt_hi, tgt;
	logic signed [32:0] diff;
	always_comb begin
		tgt_hi = ($signed(target_position) > max_pos_q) ? max_pos_q
		         : $signed(target_position);
		tgt    = (tgt_hi < min_pos_q) ? min_pos_q : tgt_hi;
		diff   = {tgt[31], tgt} - {cur_pos_q[31], cur_pos_q};
	end

	// Decide the command on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q <= '0;
			homed_q   <= 1'b0;
			need_q    <= 1'b0;
			st_q      <= ST_MOVED;
			dist_q    <= '0;
		end else if (cmd.load) begin
			need_q <= (kind != KIND_HOME) && connected_q && enabled_q && homed_q
			          && (tgt != cur_pos_q);
			priority if (kind == KIND_HOME) begin
				homed_q <= 1'b1;
				st_q    <= ST_HOMED;
			end else if (!connected_q) begin
				st_q <= ST_NOT_CONN;
			end else if (!enabled_q) begin
				st_q <= ST_NOT_EN;
			end else if (!homed_q) begin
				st_q <= ST_NOT_HOMED;
			end else if (tgt == cur_pos_q) begin
				st_q <= ST_ALREADY;
			end else begin
				st_q      <= ST_MOVED;
				cur_pos_q <= tgt;
				dist_q    <= diff[32] ? 32'(-diff) : diff[31:0];
			end
		end
	end

	// Shared 32x32 multiplier with registered results
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_DA: begin mul_a = dist_q;   mul_b = a_eff; end
			MUL_VV: begin mul_a = v_eff;    mul_b = v_eff; end
			MUL_VA: begin mul_a = v_eff;    mul_b = a_eff; end
			MUL_KD: begin mul_a = SQ_SCALE; mul_b = dist_q; end
			default: begin mul_a = '0;      mul_b = '0; end
		endcase
		mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_DA, MUL_KD: da_q <= mul_p;
				MUL_VV:         vv_q <= mul_p;
				MUL_VA:         va_q <= mul_p;
				default: ;
			endcase
		end
		if (cmd.latch_short) begin
			short_q <= (da_q < vv_q);
		end
	end

	// Long move dividend: 2000*(d*a + v*v) + v*a
	logic [64:0]      sum_s;
	logic [DVD_W-1:0] sum_w, num_long;
	always_comb begin
		sum_s    = {1'b0, da_q} + {1'b0, vv_q};
		sum_w    = {{(DVD_W-65){1'b0}}, sum_s};
		num_long = (sum_w << 11) - (sum_w << 5) - (sum_w << 4)
		         + {{(DVD_W-64){1'b0}}, va_q};
	end

	// Restoring divider, one quotient bit per step
	logic [DEN_W:0] rem_sh;
	logic           rem_ge;
	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], dvd_q[DVD_W-1]};
		rem_ge = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q <= short_q ? {{(DVD_W-64){1'b0}}, da_q} : num_long;
			den_q <= short_q ? {{(DEN_W-32){1'b0}}, a_eff} : {va_q, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], rem_ge};
		end
	end

	// Digit-by-digit square root, two radicand bits per step
	logic [SQ_W-1:0] sq_t;
	assign sq_t = sqr_q + sqb_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			sqn_q <= quo_q[SQ_W-1:0];
			sqr_q <= '0;
			sqb_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (cmd.sq_step) begin
			if (sqn_q >= sq_t) begin
				sqn_q <= sqn_q - sq_t;
				sqr_q <= (sqr_q >> 1) + sqb_q;
			end else begin
				sqr_q <= sqr_q >> 1;
			end
			sqb_q <= sqb_q >> 2;
		end
	end

	// Round the root or saturate the quotient
	logic [29:0] m_sum;
	assign m_sum = {1'b0, sqr_q[28:0]} + 30'd1;

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (short_q) begin
				ms_q <= {3'b0, m_sum[29:1]};
			end else begin
				ms_q <= (|quo_q[DVD_W-1:32]) ? '1 : quo_q[31:0];
			end
		end
	end

	// Output register
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.need_time  = need_q;
	assign sts.short_move = short_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_st_q  <= st_q;
			out_pos_q <= cur_pos_q;
			out_ms_q  <= (st_q == ST_MOVED) ? ms_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign position     = out_pos_q;
	assign move_time_ms = out_ms_q;

endmodule

// ----- rtl/smte_checker.sv -----
// Port-level checks for the stage move time estimator, bound to the top.
// Depends on smte_pkg and stage_move_time_estimator.
`timescale 1ns / 1ps
module smte_checker import smte_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] position,
	input logic [31:0] move_time_ms
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)
		&& $stable(position) && $stable(move_time_ms)))
		else $error("stalled result changed");

	// Time is zero unless the stage moved
	a_ms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_MOVED) |-> (move_time_ms == '0))
		else $error("nonzero time without a move");

	// Status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_HOMED))
		else $error("bad status code");

	// Stall after each accepted transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken while busy");

endmodule

bind stage_move_time_estimator smte_checker u_smte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.position     (position),
	.move_time_ms (move_time_ms)
);
